// ----- hdl/tkeo_pkg.sv -----
// Shared types, constants and the multiply step table of the TKEO vote detector.
`default_nettype none

package tkeo_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int NUM_CH          = 4;
   localparam int CH_W            = 2;
   localparam int CFG_IDX_W       = 3;
   localparam int CFG_DATA_W      = 64;
   localparam int THR_W           = 64;
   localparam int FEAT_W          = 33;
   localparam int CUBIC_W         = 64;
   localparam int VOTE_W          = 2;
   localparam int REFR_W          = 16;
   localparam int MUL_W           = 32;
   localparam int LIMB_W          = 24;
   localparam int CUBE_W          = 2 * LIMB_W;
   localparam int ACC_W           = 96;
   localparam int STEP_W          = 5;
   localparam int NUM_SMP_OPD     = 9;
   localparam int NUM_OPD         = 16;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_ENERGY_CH  = 3'd0,
      CSR_CUBIC_CH   = 3'd1,
      CSR_SPATIAL_CH = 3'd2,
      CSR_ENERGY_THR = 3'd3,
      CSR_CUBIC_THR  = 3'd4,
      CSR_SPATIAL_THR = 3'd5,
      CSR_MIN_VOTES  = 3'd6,
      CSR_REFRACTORY = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      OPD_X0E   = 4'd0,
      OPD_X1E   = 4'd1,
      OPD_X2E   = 4'd2,
      OPD_S0    = 4'd3,
      OPD_S1    = 4'd4,
      OPD_S2    = 4'd5,
      OPD_X0C   = 4'd6,
      OPD_X1C   = 4'd7,
      OPD_X2C   = 4'd8,
      OPD_SQ    = 4'd9,
      OPD_CA_LO = 4'd10,
      OPD_CA_HI = 4'd11,
      OPD_CB_LO = 4'd12,
      OPD_CB_HI = 4'd13,
      OPD_CC_LO = 4'd14,
      OPD_CC_HI = 4'd15
   } opd_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_LIMB,
      SH_LIMB_X2,
      SH_TWO_LIMB
   } shift_type;

   typedef enum logic [2:0] {
      DST_ACC,
      DST_SQ,
      DST_CA,
      DST_CB,
      DST_CC
   } dest_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_ENERGY,
      CAP_SPATIAL
   } cap_type;

   typedef struct packed {
      opd_type   src_a;
      opd_type   src_b;
      shift_type shift;
      logic      load;
      logic      sub;
      dest_type  dest;
      cap_type   cap;
   } step_op_type;

   typedef struct packed {
      logic              neg;
      logic [MUL_W-1:0]  mag;
   } opnd_type;

   typedef struct packed {
      logic        en;
      step_op_type op;
   } mac_ctrl_type;

   typedef struct packed {
      logic idle;
      logic sat_en;
      logic out_load;
   } seq_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_SAT,
      ST_VOTE
   } seq_state_type;

   function automatic step_op_type mk_op(input opd_type a, input opd_type b,
                                         input shift_type sh, input logic ld,
                                         input logic sb, input dest_type d,
                                         input cap_type c);
      step_op_type op;
      op.src_a = a;
      op.src_b = b;
      op.shift = sh;
      op.load  = ld;
      op.sub   = sb;
      op.dest  = d;
      op.cap   = c;
      return op;
   endfunction

   function automatic step_op_type step_op(input logic [STEP_W-1:0] idx);
      step_op_type op;
      unique case (idx)
         5'd0:  op = mk_op(OPD_X1E, OPD_X1E, SH_NONE, 1'b1, 1'b0, DST_ACC, CAP_NONE);
         5'd1:  op = mk_op(OPD_X0E, OPD_X2E, SH_NONE, 1'b0, 1'b1, DST_ACC, CAP_ENERGY);
         5'd2:  op = mk_op(OPD_S1, OPD_S1, SH_NONE, 1'b1, 1'b0, DST_ACC, CAP_NONE);
         5'd3:  op = mk_op(OPD_S0, OPD_S2, SH_NONE, 1'b0, 1'b1, DST_ACC, CAP_SPATIAL);
         5'd4:  op = mk_op(OPD_X0C, OPD_X0C, SH_NONE, 1'b0, 1'b0, DST_SQ, CAP_NONE);
         5'd5:  op = mk_op(OPD_SQ, OPD_X0C, SH_NONE, 1'b0, 1'b0, DST_CA, CAP_NONE);
         5'd6:  op = mk_op(OPD_X1C, OPD_X1C, SH_NONE, 1'b0, 1'b0, DST_SQ, CAP_NONE);
         5'd7:  op = mk_op(OPD_SQ, OPD_X1C, SH_NONE, 1'b0, 1'b0, DST_CB, CAP_NONE);
         5'd8:  op = mk_op(OPD_X2C, OPD_X2C, SH_NONE, 1'b0, 1'b0, DST_SQ, CAP_NONE);
         5'd9:  op = mk_op(OPD_SQ, OPD_X2C, SH_NONE, 1'b0, 1'b0, DST_CC, CAP_NONE);
         5'd10: op = mk_op(OPD_CB_LO, OPD_CB_LO, SH_NONE, 1'b1, 1'b0, DST_ACC, CAP_NONE);
         5'd11: op = mk_op(OPD_CB_LO, OPD_CB_HI, SH_LIMB_X2, 1'b0, 1'b0, DST_ACC, CAP_NONE);
         5'd12: op = mk_op(OPD_CB_HI, OPD_CB_HI, SH_TWO_LIMB, 1'b0, 1'b0, DST_ACC, CAP_NONE);
         5'd13: op = mk_op(OPD_CA_LO, OPD_CC_LO, SH_NONE, 1'b0, 1'b1, DST_ACC, CAP_NONE);
         5'd14: op = mk_op(OPD_CA_LO, OPD_CC_HI, SH_LIMB, 1'b0, 1'b1, DST_ACC, CAP_NONE);
         5'd15: op = mk_op(OPD_CA_HI, OPD_CC_LO, SH_LIMB, 1'b0, 1'b1, DST_ACC, CAP_NONE);
         5'd16: op = mk_op(OPD_CA_HI, OPD_CC_HI, SH_TWO_LIMB, 1'b0, 1'b1, DST_ACC, CAP_NONE);
         default: op = mk_op(OPD_SQ, OPD_SQ, SH_NONE, 1'b0, 1'b0, DST_SQ, CAP_NONE);
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tkeo_req_if.sv -----
// Sample request channel: valid, ready and one four-channel sample.
`default_nettype none

interface tkeo_req_if
   import tkeo_pkg::*;
   #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] ch0_sample;
   logic signed [SAMPLE_BITS-1:0] ch1_sample;
   logic signed [SAMPLE_BITS-1:0] ch2_sample;
   logic signed [SAMPLE_BITS-1:0] ch3_sample;

   modport source (output valid, output ch0_sample, output ch1_sample,
                   output ch2_sample, output ch3_sample, input ready);
   modport sink (input valid, input ch0_sample, input ch1_sample,
                 input ch2_sample, input ch3_sample, output ready);

endinterface

`default_nettype wire

// ----- hdl/tkeo_rsp_if.sv -----
// Detection response channel: valid, ready and the features and vote result.
`default_nettype none

interface tkeo_rsp_if
   import tkeo_pkg::*;
   ;

   logic                      valid;
   logic                      ready;
   logic                      detect;
   logic [VOTE_W-1:0]         vote_count;
   logic                      in_refractory;
   logic signed [FEAT_W-1:0]  energy_feature;
   logic signed [CUBIC_W-1:0] cubic_feature;
   logic signed [FEAT_W-1:0]  spatial_feature;

   modport source (output valid, output detect, output vote_count,
                   output in_refractory, output energy_feature,
                   output cubic_feature, output spatial_feature, input ready);
   modport sink (input valid, input detect, input vote_count,
                 input in_refractory, input energy_feature,
                 input cubic_feature, input spatial_feature, output ready);

endinterface

`default_nettype wire

// ----- hdl/tkeo_threshold_vote_detector_core.sv -----
// Top level of the TKEO threshold vote detector: registers, history, votes, response.
//
//   channel | direction | handshake          | payload
//   req     | in        | valid / ready      | ch0..ch3_sample
//   rsp     | out       | valid / ready      | detect, vote_count, in_refractory, features
//   csr     | in        | csr_wr_en (write)  | csr_index, csr_wr_data
//
// A primed item passes a transfer, 17 steps on the single 32x32 multiplier
// (energy 2, spatial 2, three cubes 6, cubic energy 7), a saturate step and a vote step.
// The first two items after reset only fill the history and are taken one per cycle.
// Synchronous reset loads the configuration defaults and clears fill count, refractory count and sequencer.
// A stalled response holds the vote step; a new request transfers while a response waits.
`default_nettype none

module tkeo_threshold_vote_detector_core
   import tkeo_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tkeo_req_if.sink                   req_chan,
   tkeo_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wr_data
);

   logic [CH_W-1:0]         energy_ch_ff;
   logic [CH_W-1:0]         cubic_ch_ff;
   logic [CH_W-1:0]         spatial_ch_ff;
   logic signed [THR_W-1:0] energy_thr_ff;
   logic signed [THR_W-1:0] cubic_thr_ff;
   logic signed [THR_W-1:0] spatial_thr_ff;
   logic [VOTE_W-1:0]       min_votes_ff;
   logic [REFR_W-1:0]       refr_len_ff;

   logic signed [SAMPLE_BITS-1:0] in_smp  [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] hist0_ff [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] hist1_ff [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] cur_ff   [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] smp_opd  [NUM_SMP_OPD];
   logic [1:0]                    fill_ff;
   logic                          primed;
   logic                          accept;
   logic                          out_free;
   logic [CH_W-1:0]               spatial_ch1;
   logic [CH_W-1:0]               spatial_ch2;

   mac_ctrl_type              mac_ctrl;
   seq_ctrl_type              seq_ctrl;
   logic signed [FEAT_W-1:0]  energy;
   logic signed [FEAT_W-1:0]  spatial;
   logic signed [ACC_W-1:0]   acc;
   logic signed [CUBIC_W-1:0] cubic_ff;
   logic signed [CUBIC_W-1:0] cubic_in;

   logic                      energy_vote;
   logic                      cubic_vote;
   logic                      spatial_vote;
   logic [VOTE_W-1:0]         votes;
   logic [REFR_W-1:0]         refr_left_ff;
   logic [REFR_W-1:0]         refr_left_in;
   logic                      det;
   logic                      inref;

   logic                      rsp_valid_ff;
   logic                      detect_ff;
   logic [VOTE_W-1:0]         vote_count_ff;
   logic                      in_refractory_ff;
   logic signed [FEAT_W-1:0]  energy_out_ff;
   logic signed [CUBIC_W-1:0] cubic_out_ff;
   logic signed [FEAT_W-1:0]  spatial_out_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ch_ff   <= '0;
         cubic_ch_ff    <= '0;
         spatial_ch_ff  <= CH_W'(3);
         energy_thr_ff  <= '0;
         cubic_thr_ff   <= '0;
         spatial_thr_ff <= '0;
         min_votes_ff   <= VOTE_W'(1);
         refr_len_ff    <= REFR_W'(205);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENERGY_CH:   energy_ch_ff   <= csr_wr_data[CH_W-1:0];
            CSR_CUBIC_CH:    cubic_ch_ff    <= csr_wr_data[CH_W-1:0];
            CSR_SPATIAL_CH:  spatial_ch_ff  <= csr_wr_data[CH_W-1:0];
            CSR_ENERGY_THR:  energy_thr_ff  <= csr_wr_data[THR_W-1:0];
            CSR_CUBIC_THR:   cubic_thr_ff   <= csr_wr_data[THR_W-1:0];
            CSR_SPATIAL_THR: spatial_thr_ff <= csr_wr_data[THR_W-1:0];
            CSR_MIN_VOTES:   min_votes_ff   <= csr_wr_data[VOTE_W-1:0];
            CSR_REFRACTORY:  refr_len_ff    <= csr_wr_data[REFR_W-1:0];
         endcase
      end
   end

   // request side and sample history
   assign in_smp[0] = req_chan.ch0_sample;
   assign in_smp[1] = req_chan.ch1_sample;
   assign in_smp[2] = req_chan.ch2_sample;
   assign in_smp[3] = req_chan.ch3_sample;

   assign primed         = fill_ff[1];
   assign req_chan.ready = seq_ctrl.idle;
   assign accept         = req_chan.valid && seq_ctrl.idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept && !primed) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && primed) begin
         cur_ff <= in_smp;
      end else if (accept) begin
         hist0_ff <= hist1_ff;
         hist1_ff <= in_smp;
      end else if (seq_ctrl.out_load) begin
         hist0_ff <= hist1_ff;
         hist1_ff <= cur_ff;
      end
   end

   assign spatial_ch1 = spatial_ch_ff + 1'b1;
   assign spatial_ch2 = spatial_ch_ff + 2'd2;

   always_comb begin
      smp_opd[OPD_X0E] = hist0_ff[energy_ch_ff];
      smp_opd[OPD_X1E] = hist1_ff[energy_ch_ff];
      smp_opd[OPD_X2E] = cur_ff[energy_ch_ff];
      smp_opd[OPD_S0]  = hist0_ff[spatial_ch_ff];
      smp_opd[OPD_S1]  = hist0_ff[spatial_ch1];
      smp_opd[OPD_S2]  = hist0_ff[spatial_ch2];
      smp_opd[OPD_X0C] = hist0_ff[cubic_ch_ff];
      smp_opd[OPD_X1C] = hist1_ff[cubic_ch_ff];
      smp_opd[OPD_X2C] = cur_ff[cubic_ch_ff];
   end

   tkeo_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && primed),
      .out_free (out_free),
      .mac_ctrl (mac_ctrl),
      .seq_ctrl (seq_ctrl)
   );

   tkeo_mac_unit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .smp     (smp_opd),
      .energy  (energy),
      .spatial (spatial),
      .acc     (acc)
   );

   // saturate the cubic energy to 64 bits
   always_comb begin
      if ((acc[ACC_W-1:CUBIC_W-1] == '0) || (acc[ACC_W-1:CUBIC_W-1] == '1)) begin
         cubic_in = acc[CUBIC_W-1:0];
      end else if (acc[ACC_W-1]) begin
         cubic_in = {1'b1, {(CUBIC_W-1){1'b0}}};
      end else begin
         cubic_in = {1'b0, {(CUBIC_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctrl.sat_en) begin
         cubic_ff <= cubic_in;
      end
   end

   // votes and refractory window
   always_comb begin
      energy_vote  = THR_W'(energy) > energy_thr_ff;
      cubic_vote   = cubic_ff > cubic_thr_ff;
      spatial_vote = THR_W'(spatial) > spatial_thr_ff;
      votes        = VOTE_W'(energy_vote) + VOTE_W'(cubic_vote) + VOTE_W'(spatial_vote);
      det          = 1'b0;
      inref        = 1'b0;
      refr_left_in = refr_left_ff;
      if (refr_left_ff != '0) begin
         inref        = 1'b1;
         refr_left_in = refr_left_ff - 1'b1;
      end else if (votes >= min_votes_ff) begin
         det          = 1'b1;
         refr_left_in = (refr_len_ff == '0) ? '0 : refr_len_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refr_left_ff <= '0;
      end else if (seq_ctrl.out_load) begin
         refr_left_ff <= refr_left_in;
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctrl.out_load) begin
         detect_ff        <= det;
         vote_count_ff    <= votes;
         in_refractory_ff <= inref;
         energy_out_ff    <= energy;
         cubic_out_ff     <= cubic_ff;
         spatial_out_ff   <= spatial;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.detect          = detect_ff;
   assign rsp_chan.vote_count      = vote_count_ff;
   assign rsp_chan.in_refractory   = in_refractory_ff;
   assign rsp_chan.energy_feature  = energy_out_ff;
   assign rsp_chan.cubic_feature   = cubic_out_ff;
   assign rsp_chan.spatial_feature = spatial_out_ff;

endmodule

`default_nettype wire

// ----- hdl/tkeo_mac_unit.sv -----
// Shared sign-magnitude multiplier with wide accumulator, square and cube registers.
`default_nettype none

module tkeo_mac_unit
   import tkeo_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire mac_ctrl_type                  ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] smp [NUM_SMP_OPD],
   output logic signed [FEAT_W-1:0]           energy,
   output logic signed [FEAT_W-1:0]           spatial,
   output logic signed [ACC_W-1:0]            acc
);

   logic [SAMPLE_BITS:0]  smp_ext [NUM_SMP_OPD];
   logic [SAMPLE_BITS:0]  smp_mag [NUM_SMP_OPD];
   opnd_type              opnd [NUM_OPD];
   opnd_type              opa;
   opnd_type              opb;
   logic [2*MUL_W-1:0]    prod;
   logic [ACC_W-1:0]      term;
   logic [ACC_W-1:0]      base;
   logic                  neg;
   logic [ACC_W-1:0]      acc_in;
   logic [ACC_W-1:0]      acc_ff;
   logic [MUL_W-1:0]      sq_ff;
   logic [CUBE_W-1:0]     ca_ff;
   logic [CUBE_W-1:0]     cb_ff;
   logic [CUBE_W-1:0]     cc_ff;
   logic                  ca_neg_ff;
   logic                  cc_neg_ff;
   logic [FEAT_W-1:0]     energy_ff;
   logic [FEAT_W-1:0]     spatial_ff;

   always_comb begin
      for (int i = 0; i < NUM_SMP_OPD; i++) begin
         smp_ext[i] = {smp[i][SAMPLE_BITS-1], smp[i]};
         smp_mag[i] = smp_ext[i][SAMPLE_BITS] ? (~smp_ext[i] + 1'b1) : smp_ext[i];
         opnd[i].neg = smp_ext[i][SAMPLE_BITS];
         opnd[i].mag = MUL_W'(smp_mag[i]);
      end
      opnd[OPD_SQ].neg    = 1'b0;
      opnd[OPD_SQ].mag    = sq_ff;
      opnd[OPD_CA_LO].neg = ca_neg_ff;
      opnd[OPD_CA_LO].mag = MUL_W'(ca_ff[LIMB_W-1:0]);
      opnd[OPD_CA_HI].neg = ca_neg_ff;
      opnd[OPD_CA_HI].mag = MUL_W'(ca_ff[CUBE_W-1:LIMB_W]);
      opnd[OPD_CB_LO].neg = 1'b0;
      opnd[OPD_CB_LO].mag = MUL_W'(cb_ff[LIMB_W-1:0]);
      opnd[OPD_CB_HI].neg = 1'b0;
      opnd[OPD_CB_HI].mag = MUL_W'(cb_ff[CUBE_W-1:LIMB_W]);
      opnd[OPD_CC_LO].neg = cc_neg_ff;
      opnd[OPD_CC_LO].mag = MUL_W'(cc_ff[LIMB_W-1:0]);
      opnd[OPD_CC_HI].neg = cc_neg_ff;
      opnd[OPD_CC_HI].mag = MUL_W'(cc_ff[CUBE_W-1:LIMB_W]);
   end

   always_comb begin
      opa  = opnd[ctrl.op.src_a];
      opb  = opnd[ctrl.op.src_b];
      prod = opa.mag * opb.mag;
      neg  = ctrl.op.sub ^ opa.neg ^ opb.neg;
      unique case (ctrl.op.shift)
         SH_NONE:     term = ACC_W'(prod);
         SH_LIMB:     term = ACC_W'(prod) << LIMB_W;
         SH_LIMB_X2:  term = ACC_W'(prod) << (LIMB_W + 1);
         SH_TWO_LIMB: term = ACC_W'(prod) << (2 * LIMB_W);
      endcase
      base   = ctrl.op.load ? '0 : acc_ff;
      acc_in = base + (term ^ {ACC_W{neg}}) + ACC_W'(neg);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         unique case (ctrl.op.dest)
            DST_ACC: acc_ff <= acc_in;
            DST_SQ:  sq_ff  <= prod[MUL_W-1:0];
            DST_CA: begin
               ca_ff     <= prod[CUBE_W-1:0];
               ca_neg_ff <= neg;
            end
            DST_CB:  cb_ff  <= prod[CUBE_W-1:0];
            DST_CC: begin
               cc_ff     <= prod[CUBE_W-1:0];
               cc_neg_ff <= neg;
            end
            default: sq_ff <= sq_ff;
         endcase
         unique case (ctrl.op.cap)
            CAP_ENERGY:  energy_ff  <= acc_in[FEAT_W-1:0];
            CAP_SPATIAL: spatial_ff <= acc_in[FEAT_W-1:0];
            default:     energy_ff  <= energy_ff;
         endcase
      end
   end

   assign energy  = energy_ff;
   assign spatial = spatial_ff;
   assign acc     = acc_ff;

endmodule

`default_nettype wire

// ----- hdl/tkeo_sequencer.sv -----
// Step sequencer: walks the multiply table, then saturation and vote steps.
`default_nettype none

module tkeo_sequencer
   import tkeo_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    out_free,
   output mac_ctrl_type mac_ctrl,
   output seq_ctrl_type seq_ctrl
);

   seq_state_type     state_ff;
   seq_state_type     state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            state_in = ST_VOTE;
         end
         ST_VOTE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      mac_ctrl.en       = (state_ff == ST_CALC);
      mac_ctrl.op       = step_op(step_ff);
      seq_ctrl.idle     = (state_ff == ST_IDLE);
      seq_ctrl.sat_en   = (state_ff == ST_SAT);
      seq_ctrl.out_load = (state_ff == ST_VOTE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- dv/tkeo_detect_checker.sv -----
// Response checker for the TKEO vote detector: tracks the sample history and compares results.
`timescale 1ns / 1ps

module tkeo_detect_checker
   import tkeo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tkeo_req_if                        req_mon,
   tkeo_rsp_if                        rsp_mon,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_DATA_W-1:0] csr_wr_data,
   output int unsigned                mismatch_count,
   output int unsigned                outstanding
);

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_type;

   typedef struct packed {
      logic                      detect;
      logic [VOTE_W-1:0]         vote_count;
      logic                      in_refractory;
      logic signed [FEAT_W-1:0]  energy;
      logic signed [CUBIC_W-1:0] cubic;
      logic signed [FEAT_W-1:0]  spatial;
   } detection_type;

   localparam logic signed [127:0] CUBIC_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] CUBIC_MIN = -CUBIC_MAX - 128'sd1;

   logic [CH_W-1:0]         energy_ch, cubic_ch, spatial_ch;
   logic signed [THR_W-1:0] energy_thr, cubic_thr, spatial_thr;
   logic [VOTE_W-1:0]       vote_floor;
   logic [REFR_W-1:0]       refr_len;

   sample_type        hist_old [NUM_CH];
   sample_type        hist_mid [NUM_CH];
   logic [1:0]        primed;
   logic [REFR_W-1:0] refr_left;

   detection_type expected_detections [$];
   int unsigned   errors;

   function automatic void predict_detection(input sample_type n0, input sample_type n1,
                                             input sample_type n2, input sample_type n3);
      sample_type          fresh [NUM_CH];
      longint              e0, e1, e2, p0, p1, p2, energy, spatial;
      logic signed [127:0] w0, w1, w2, cube_diff;
      logic signed [CUBIC_W-1:0] cubic;
      logic [VOTE_W-1:0]   votes;
      logic [CH_W-1:0]     ps1, ps2;
      detection_type       res;
      fresh[0] = n0;
      fresh[1] = n1;
      fresh[2] = n2;
      fresh[3] = n3;
      if (primed == 2'd2) begin
         e0 = longint'(hist_old[energy_ch]);
         e1 = longint'(hist_mid[energy_ch]);
         e2 = longint'(fresh[energy_ch]);
         energy = e1 * e1 - e0 * e2;

         w0 = 128'(hist_old[cubic_ch]);
         w1 = 128'(hist_mid[cubic_ch]);
         w2 = 128'(fresh[cubic_ch]);
         w0 = w0 * w0 * w0;
         w1 = w1 * w1 * w1;
         w2 = w2 * w2 * w2;
         cube_diff = w1 * w1 - w0 * w2;
         if (cube_diff > CUBIC_MAX) begin
            cubic = CUBIC_MAX[CUBIC_W-1:0];
         end else if (cube_diff < CUBIC_MIN) begin
            cubic = CUBIC_MIN[CUBIC_W-1:0];
         end else begin
            cubic = cube_diff[CUBIC_W-1:0];
         end

         ps1 = spatial_ch + 2'd1;
         ps2 = spatial_ch + 2'd2;
         p0 = longint'(hist_old[spatial_ch]);
         p1 = longint'(hist_old[ps1]);
         p2 = longint'(hist_old[ps2]);
         spatial = p1 * p1 - p0 * p2;

         votes = '0;
         if (energy > energy_thr) votes++;
         if (cubic > cubic_thr) votes++;
         if (spatial > spatial_thr) votes++;

         res = '0;
         res.vote_count = votes;
         res.energy     = energy[FEAT_W-1:0];
         res.cubic      = cubic;
         res.spatial    = spatial[FEAT_W-1:0];
         if (refr_left != '0) begin
            res.in_refractory = 1'b1;
            refr_left--;
         end else if (votes >= vote_floor) begin
            res.detect = 1'b1;
            refr_left = (refr_len == '0) ? '0 : refr_len - 1'b1;
         end
         expected_detections.insert(expected_detections.size(), res);
      end else begin
         primed++;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         hist_old[c] = hist_mid[c];
         hist_mid[c] = fresh[c];
      end
   endfunction

   always @(posedge clock) begin : monitor
      detection_type got, want;
      if (reset) begin
         energy_ch   = '0;
         cubic_ch    = '0;
         spatial_ch  = 2'd3;
         energy_thr  = '0;
         cubic_thr   = '0;
         spatial_thr = '0;
         vote_floor  = 2'd1;
         refr_len    = 16'd205;
         for (int c = 0; c < NUM_CH; c++) begin
            hist_old[c] = '0;
            hist_mid[c] = '0;
         end
         primed    = '0;
         refr_left = '0;
         expected_detections.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ENERGY_CH:   energy_ch   = csr_wr_data[CH_W-1:0];
               CSR_CUBIC_CH:    cubic_ch    = csr_wr_data[CH_W-1:0];
               CSR_SPATIAL_CH:  spatial_ch  = csr_wr_data[CH_W-1:0];
               CSR_ENERGY_THR:  energy_thr  = csr_wr_data;
               CSR_CUBIC_THR:   cubic_thr   = csr_wr_data;
               CSR_SPATIAL_THR: spatial_thr = csr_wr_data;
               CSR_MIN_VOTES:   vote_floor  = csr_wr_data[VOTE_W-1:0];
               CSR_REFRACTORY:  refr_len    = csr_wr_data[REFR_W-1:0];
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.detect        = rsp_mon.detect;
            got.vote_count    = rsp_mon.vote_count;
            got.in_refractory = rsp_mon.in_refractory;
            got.energy        = rsp_mon.energy_feature;
            got.cubic         = rsp_mon.cubic_feature;
            got.spatial       = rsp_mon.spatial_feature;
            if (expected_detections.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected response det=%0b votes=%0d refr=%0b", $realtime,
                           got.detect, got.vote_count, got.in_refractory);
            end else begin
               want = expected_detections.pop_front();
               if (got.detect !== want.detect || got.vote_count !== want.vote_count ||
                   got.in_refractory !== want.in_refractory || got.energy !== want.energy ||
                   got.cubic !== want.cubic || got.spatial !== want.spatial) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("  expected det=%0b votes=%0d refr=%0b en=%0d cu=%0d sp=%0d",
                              want.detect, want.vote_count, want.in_refractory,
                              want.energy, want.cubic, want.spatial);
                     $display("  actual   det=%0b votes=%0d refr=%0b en=%0d cu=%0d sp=%0d",
                              got.detect, got.vote_count, got.in_refractory,
                              got.energy, got.cubic, got.spatial);
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            predict_detection(req_mon.ch0_sample, req_mon.ch1_sample,
                              req_mon.ch2_sample, req_mon.ch3_sample);
      end
      mismatch_count <= errors;
      outstanding    <= expected_detections.size();
   end

endmodule

// ----- dv/tb.sv -----
// Testbench top of the TKEO vote detector: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
   import tkeo_pkg::*;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_type;

   localparam int NUM_CSR        = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int DIRECTED_ITEMS = 20;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 44;
   localparam int HOLD_PHASE     = 4;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_DATA_W-1:0] csr_wr_data;
   bit                    hold_req, hold_done, quiet;
   int unsigned           mismatch_count, outstanding, idle_cycles;

   tkeo_req_if req_chan ();
   tkeo_rsp_if rsp_chan ();

   always #6 clock = ~clock;

   tkeo_threshold_vote_detector_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tkeo_detect_checker u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   function automatic logic [63:0] directed_frame(input int unsigned idx);
      case (idx)
         0:  return 64'h0000_0000_0000_0000;
         1:  return 64'h8000_0001_FFFF_7FFF;
         2:  return 64'h7FFF_FFFF_0001_8000;
         3:  return 64'h0001_7FFF_8000_8000;
         4:  return 64'hFFFF_8000_7FFF_7FFF;
         5:  return 64'h5555_AAAA_5555_0000;
         6:  return 64'hAAAA_5555_AAAA_7FFF;
         7:  return 64'h7FFF_7FFF_7FFF_7FFF;
         8:  return 64'h8000_8000_8000_8000;
         9:  return 64'h7FFF_7FFF_7FFF_7FFF;
         10: return 64'h0001_0001_0001_0001;
         11: return 64'hFFFF_FFFF_FFFF_FFFF;
         12: return 64'h0000_0000_0000_0000;
         13: return 64'h1234_EDCB_0F0F_F0F0;
         14: return 64'h8000_7FFF_8000_7FFF;
         15: return 64'h0000_0000_0000_0000;
         16: return 64'h7FFF_8000_7FFF_8000;
         17: return 64'h00FF_FF00_0100_FEFF;
         18: return 64'h5555_5555_AAAA_AAAA;
         default: return 64'hAAAA_AAAA_5555_5555;
      endcase
   endfunction

   function automatic sample_type rand_sample();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0, 1: v = 16'($urandom());
         2: begin
            case ($urandom_range(0, 3))
               0: v = 16'h7FFF;
               1: v = 16'h8000;
               2: v = 16'h0000;
               default: v = 16'hFFFF;
            endcase
         end
         3: v = 16'($urandom_range(0, 8191) - 4096);
         default: v = 16'($urandom_range(0, 255) - 128);
      endcase
      return v;
   endfunction

   function automatic logic [63:0] rand_threshold(input int unsigned top_bit);
      logic [63:0] span;
      case ($urandom_range(0, 9))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7FFF_FFFF_FFFF_FFFF;
         2: return 64'd0;
         3: return {$urandom(), $urandom()};
         default: begin
            span = {$urandom(), $urandom()} >> (63 - $urandom_range(0, top_bit));
            return ($urandom_range(0, 1) != 0) ? -span : span;
         end
      endcase
   endfunction

   function automatic logic [63:0] with_noise(input logic [63:0] val, input int unsigned width);
      return ({$urandom(), $urandom()} << width) | val;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CFG_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned phase);
      logic [CFG_DATA_W-1:0] vals [NUM_CSR];
      case (phase)
         1: begin
            vals[CSR_ENERGY_CH]   = 64'd3;
            vals[CSR_CUBIC_CH]    = 64'd3;
            vals[CSR_SPATIAL_CH]  = 64'd3;
            vals[CSR_ENERGY_THR]  = 64'h8000_0000_0000_0000;
            vals[CSR_CUBIC_THR]   = 64'h8000_0000_0000_0000;
            vals[CSR_SPATIAL_THR] = 64'h8000_0000_0000_0000;
            vals[CSR_MIN_VOTES]   = 64'd3;
            vals[CSR_REFRACTORY]  = 64'd0;
         end
         2: begin
            vals[CSR_ENERGY_CH]   = 64'd0;
            vals[CSR_CUBIC_CH]    = 64'd0;
            vals[CSR_SPATIAL_CH]  = 64'd2;
            vals[CSR_ENERGY_THR]  = 64'h7FFF_FFFF_FFFF_FFFF;
            vals[CSR_CUBIC_THR]   = 64'h7FFF_FFFF_FFFF_FFFF;
            vals[CSR_SPATIAL_THR] = 64'h7FFF_FFFF_FFFF_FFFF;
            vals[CSR_MIN_VOTES]   = 64'd0;
            vals[CSR_REFRACTORY]  = 64'd65535;
         end
         default: begin
            vals[CSR_ENERGY_CH]   = with_noise(64'($urandom_range(0, 3)), CH_W);
            vals[CSR_CUBIC_CH]    = with_noise(64'($urandom_range(0, 3)), CH_W);
            vals[CSR_SPATIAL_CH]  = with_noise(64'($urandom_range(0, 3)), CH_W);
            vals[CSR_ENERGY_THR]  = rand_threshold(32);
            vals[CSR_CUBIC_THR]   = rand_threshold(63);
            vals[CSR_SPATIAL_THR] = rand_threshold(32);
            vals[CSR_MIN_VOTES]   = with_noise(64'($urandom_range(0, 3)), VOTE_W);
            case ($urandom_range(0, 9))
               0: vals[CSR_REFRACTORY] = 64'd0;
               1: vals[CSR_REFRACTORY] = 64'd1;
               2: vals[CSR_REFRACTORY] = 64'd65535;
               3: vals[CSR_REFRACTORY] = 64'd205;
               default: vals[CSR_REFRACTORY] = 64'($urandom_range(2, 12));
            endcase
            vals[CSR_REFRACTORY] = with_noise(vals[CSR_REFRACTORY], REFR_W);
         end
      endcase
      for (int i = 0; i < NUM_CSR; i++)
         write_reg(csr_index_type'(i), vals[i]);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_frame(input logic [63:0] frame);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.ch0_sample <= frame[15:0];
      req_chan.ch1_sample <= frame[31:16];
      req_chan.ch2_sample <= frame[47:32];
      req_chan.ch3_sample <= frame[63:48];
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_side
      int unsigned stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD; n++) @(posedge clock);
            hold_done <= 1'b1;
         end else if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall = $urandom_range(0, 4);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("** tkeo_threshold_vote_detector_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      req_chan.valid      <= 1'b0;
      req_chan.ch0_sample <= '0;
      req_chan.ch1_sample <= '0;
      req_chan.ch2_sample <= '0;
      req_chan.ch3_sample <= '0;
      csr_wr_en           <= 1'b0;
      csr_index           <= '0;
      csr_wr_data         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ITEMS; i++)
         send_frame(directed_frame(i));

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         req_chan.valid <= 1'b0;
         wait_idle();
         configure(phase);
         if (phase == HOLD_PHASE) hold_req <= 1'b1;
         if (phase == NUM_PHASES) quiet <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_frame({rand_sample(), rand_sample(), rand_sample(), rand_sample()});
      end
      req_chan.valid <= 1'b0;
      wait_idle();

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("** tkeo_threshold_vote_detector_core: PASSED **");
      end else begin
         $display("** tkeo_threshold_vote_detector_core: FAILED **");
      end
      $finish;
   end

endmodule
